// File: hw/rtl/soc_pkg.sv
// Shared constants, types and helpers for the scan obstacle clustering block.
// Used by the top level; no dependencies.
package soc_pkg;

  // POINTS_PER_TURN must be at least 256 for the window wrap below
  localparam int POINTS_PER_TURN = 360;
  localparam int PT_ADDR_W       = $clog2(POINTS_PER_TURN);
  localparam int PT_CNT_W        = $clog2(POINTS_PER_TURN + 1);
  localparam int WIN_W           = ((PT_ADDR_W > 9) ? PT_ADDR_W : 9) + 1;

  localparam int COORD_W    = 16;
  localparam int POINT_W    = 2 * COORD_W;
  localparam int COUNT_W    = 9;
  localparam int DIST_W     = 31;
  localparam int JOIN_W     = 26;
  localparam int RANGE_W    = 15;
  localparam int WINDOW_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_JOIN_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_WIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_WIN    = 3'd4;

  localparam logic [JOIN_W-1:0]   JOIN_DIST_RST   = 26'd62500;
  localparam logic [DIST_W-1:0]   DANGER_DIST_RST = 31'd1000000;
  localparam logic [RANGE_W-1:0]  RANGE_LIMIT_RST = 15'd4000;
  localparam logic [WINDOW_W-1:0] FRONT_WIN_RST   = 9'd180;
  localparam logic [WINDOW_W-1:0] NEAR_WIN_RST    = 9'd60;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BACK   = 4'b0010,
    ST_FWD    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // index lies in a window of full width w centered on index 0
  function automatic logic in_window(input logic [PT_ADDR_W-1:0] idx,
                                     input logic [WINDOW_W-1:0] w);
    logic [WIN_W-1:0] pos;
    pos = WIN_W'(idx) + WIN_W'(w[WINDOW_W-1:1]);
    if (pos >= WIN_W'(POINTS_PER_TURN)) begin
      pos = pos - WIN_W'(POINTS_PER_TURN);
    end
    return pos <= WIN_W'(w);
  endfunction

endpackage

// File: hw/rtl/scan_obstacle_clustering.sv
// Scan obstacle clustering top level: point store, segmentation passes, result.
// Depends on soc_pkg and soc_ram.
//
// Usage: points of one scan are offered on point_x/point_y with start; an item
// is taken at an edge with start high and busy low, one per cycle while idle.
// Points beyond POINTS_PER_TURN in one scan are dropped. The item with last
// set starts processing and busy stays high until the result is out.
// Processing reads the point store, one read per cycle, through a 3-stage
// gap/range/distance pipeline. The backward pass reads from the scan end
// until a break ends it (break point included) or it has run over all n
// points; the forward pass then reads the points left, and a finish step
// forms the result.
// done pulses for one cycle with obstacle_count, danger and
// nearest_distance_sq; the receiver cannot stall, so the result is simply
// presented once.
// Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once
// and are expected only while idle. Reset clears the point count, control
// state and the registers to their defaults; store contents need no reset.
module scan_obstacle_clustering
  import soc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_W-1:0]    point_x,
  input  logic signed [COORD_W-1:0]    point_y,
  input  logic                         last,
  output logic                         busy,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         done,
  output logic [COUNT_W-1:0]           obstacle_count,
  output logic                         danger,
  output logic [DIST_W-1:0]            nearest_distance_sq
);

  // configuration
  logic [JOIN_W-1:0]   join_distance_sq;
  logic [DIST_W-1:0]   danger_distance_sq;
  logic [RANGE_W-1:0]  range_limit;
  logic [WINDOW_W-1:0] front_window;
  logic [WINDOW_W-1:0] near_window;

  // control
  state_t                 state;
  logic [PT_CNT_W-1:0]    count;
  logic                   accept;
  logic                   store_en;
  logic [PT_ADDR_W-1:0]   scan_last;
  logic [PT_ADDR_W-1:0]   scan_top;
  logic [PT_ADDR_W-1:0]   fwd_last;
  logic                   issue_on;
  logic                   issue_prime;
  logic [PT_ADDR_W-1:0]   issue_addr;
  logic [POINT_W-1:0]     rd_data;

  // pipeline
  logic                       s1_v, s2_v, s3_v;
  logic                       s1_prime, s2_prime, s3_prime;
  logic [PT_ADDR_W-1:0]       s1_idx, s2_idx, s3_idx;
  logic signed [COORD_W-1:0]  prev_x, prev_y;
  logic signed [COORD_W-1:0]  cur_x, cur_y;
  logic signed [COORD_W:0]    abs_x, abs_y;
  logic signed [COORD_W:0]    s2_dx, s2_dy;
  logic signed [COORD_W-1:0]  s2_x, s2_y;
  logic                       s2_inr, s2_wf, s2_wn;
  logic signed [2*COORD_W+1:0] gx_prod, gy_prod;
  logic signed [2*COORD_W-1:0] px_prod, py_prod;
  logic [2*COORD_W-1:0]       s3_gx2, s3_gy2;
  logic [DIST_W-1:0]          s3_d2x, s3_d2y;
  logic                       s3_inr, s3_wf, s3_wn;

  // accumulators
  logic                   group_in_front;
  logic                   group_open;
  logic [COUNT_W-1:0]     group_tally;
  logic [DIST_W-1:0]      nearest_sq;
  logic                   nearest_valid;

  logic [2*COORD_W:0]     gap_sq;
  logic                   gap_gt;
  logic [DIST_W:0]        dist_sum;
  logic [DIST_W-1:0]      dist_sq;
  logic                   brk;
  logic                   add_en;
  logic                   split;
  logic                   near_hit;
  logic                   pipe_empty;
  logic                   danger_next;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign store_en = accept && (count < PT_CNT_W'(POINTS_PER_TURN));
  assign scan_last = store_en ? count[PT_ADDR_W-1:0] : PT_ADDR_W'(POINTS_PER_TURN - 1);

  soc_ram #(
    .WIDTH (POINT_W),
    .DEPTH (POINTS_PER_TURN)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (count[PT_ADDR_W-1:0]),
    .wr_data ({point_y, point_x}),
    .rd_en   (issue_on),
    .rd_addr (issue_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      join_distance_sq   <= JOIN_DIST_RST;
      danger_distance_sq <= DANGER_DIST_RST;
      range_limit        <= RANGE_LIMIT_RST;
      front_window       <= FRONT_WIN_RST;
      near_window        <= NEAR_WIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_JOIN_DIST:   join_distance_sq   <= cfg_data[JOIN_W-1:0];
        REG_DANGER_DIST: danger_distance_sq <= cfg_data[DIST_W-1:0];
        REG_RANGE_LIMIT: range_limit        <= cfg_data[RANGE_W-1:0];
        REG_FRONT_WIN:   front_window       <= cfg_data[WINDOW_W-1:0];
        REG_NEAR_WIN:    near_window        <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: read data in, differences, range and window checks
  always_comb begin
    cur_x = rd_data[COORD_W-1:0];
    cur_y = rd_data[POINT_W-1:COORD_W];
    abs_x = cur_x[COORD_W-1] ? -{cur_x[COORD_W-1], cur_x} : {1'b0, cur_x};
    abs_y = cur_y[COORD_W-1] ? -{cur_y[COORD_W-1], cur_y} : {1'b0, cur_y};
  end

  // stage 2: squares
  always_comb begin
    gx_prod = s2_dx * s2_dx;
    gy_prod = s2_dy * s2_dy;
    px_prod = s2_x * s2_x;
    py_prod = s2_y * s2_y;
  end

  // stage 3: sums, compares, decisions
  always_comb begin
    gap_sq   = {1'b0, s3_gx2} + {1'b0, s3_gy2};
    gap_gt   = gap_sq > (2*COORD_W+1)'(join_distance_sq);
    dist_sum = {1'b0, s3_d2x} + {1'b0, s3_d2y};
    dist_sq  = dist_sum[DIST_W-1:0];
    brk      = (state == ST_BACK) && s3_v && !s3_prime && (!s3_inr || gap_gt);
    add_en   = s3_v && !s3_prime && s3_inr && !((state == ST_BACK) && gap_gt);
    split    = add_en && (state == ST_FWD) && (s3_idx != '0) && gap_gt;
    near_hit = add_en && s3_wn && (!nearest_valid || (nearest_sq > dist_sq));
    pipe_empty  = !s1_v && !s2_v && !s3_v;
    danger_next = nearest_valid && (nearest_sq <= danger_distance_sq);
  end

  always_ff @(posedge clk) begin
    s1_prime <= issue_prime;
    s1_idx   <= issue_addr;
    if (s1_v) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    s2_prime <= s1_prime;
    s2_idx   <= s1_idx;
    s2_dx    <= {cur_x[COORD_W-1], cur_x} - {prev_x[COORD_W-1], prev_x};
    s2_dy    <= {cur_y[COORD_W-1], cur_y} - {prev_y[COORD_W-1], prev_y};
    s2_x     <= cur_x;
    s2_y     <= cur_y;
    s2_inr   <= (abs_x <= (COORD_W+1)'(range_limit)) && (abs_y <= (COORD_W+1)'(range_limit));
    s2_wf    <= in_window(s1_idx, front_window);
    s2_wn    <= in_window(s1_idx, near_window);
    s3_prime <= s2_prime;
    s3_idx   <= s2_idx;
    s3_gx2   <= gx_prod[2*COORD_W-1:0];
    s3_gy2   <= gy_prod[2*COORD_W-1:0];
    s3_d2x   <= px_prod[DIST_W-1:0];
    s3_d2y   <= py_prod[DIST_W-1:0];
    s3_inr   <= s2_inr;
    s3_wf    <= s2_wf;
    s3_wn    <= s2_wn;
    if (state == ST_FINISH) begin
      obstacle_count      <= group_tally + COUNT_W'(group_open);
      danger              <= danger_next;
      nearest_distance_sq <= danger_next ? nearest_sq : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      issue_on       <= 1'b0;
      issue_prime    <= 1'b0;
      issue_addr     <= '0;
      scan_top       <= '0;
      fwd_last       <= '0;
      s1_v           <= 1'b0;
      s2_v           <= 1'b0;
      s3_v           <= 1'b0;
      done           <= 1'b0;
      group_in_front <= 1'b0;
      group_open     <= 1'b0;
      group_tally    <= '0;
      nearest_sq     <= '0;
      nearest_valid  <= 1'b0;
    end else begin
      done <= 1'b0;
      s1_v <= issue_on && !brk;
      s2_v <= s1_v && !brk;
      s3_v <= s2_v && !brk;

      if (issue_on) begin
        if (issue_prime) begin
          issue_prime <= 1'b0;
          issue_addr  <= scan_top;
        end else if (state == ST_BACK) begin
          if (issue_addr == '0) begin
            issue_on <= 1'b0;
          end else begin
            issue_addr <= issue_addr - 1'b1;
          end
        end else begin
          if (issue_addr == fwd_last) begin
            issue_on <= 1'b0;
          end else begin
            issue_addr <= issue_addr + 1'b1;
          end
        end
      end

      if (add_en) begin
        group_in_front <= split ? s3_wf : (group_in_front | s3_wf);
        group_tally    <= group_tally + COUNT_W'(split && group_in_front);
        group_open     <= 1'b1;
      end
      if (near_hit) begin
        nearest_sq    <= dist_sq;
        nearest_valid <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (store_en) begin
              count <= count + 1'b1;
            end
            if (last) begin
              state          <= ST_BACK;
              issue_on       <= 1'b1;
              issue_prime    <= 1'b1;
              issue_addr     <= '0;
              scan_top       <= scan_last;
              group_in_front <= 1'b0;
              group_open     <= 1'b0;
              group_tally    <= '0;
              nearest_sq     <= '0;
              nearest_valid  <= 1'b0;
            end
          end
        end
        ST_BACK: begin
          if (brk) begin
            state       <= ST_FWD;
            fwd_last    <= s3_idx;
            issue_on    <= 1'b1;
            issue_prime <= 1'b0;
            issue_addr  <= '0;
          end else if (!issue_on && pipe_empty) begin
            state <= ST_FWD;
          end
        end
        ST_FWD: begin
          if (!issue_on && pipe_empty) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          count <= '0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without finish step");

  a_no_prime_in_fwd: assert property (@(posedge clk) disable iff (rst)
    (s3_v && (state == ST_FWD)) |-> !s3_prime)
    else $error("priming read reached the forward pass");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!issue_on && pipe_empty))
    else $error("store reads in flight while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PT_CNT_W'(POINTS_PER_TURN))
    else $error("point count beyond store depth");

endmodule

// File: hw/rtl/soc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module soc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 360
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
